>>> rtl/agal_pkg.sv
`default_nettype none

package agal_pkg;

   // default and field widths
   localparam int MAX_LEN_DEFAULT = 32;
   localparam int SYMBOL_W        = 7;
   localparam int COST_W          = 16;
   localparam int CFG_W           = 8;
   localparam int COLUMN_W        = 6;
   localparam int CSR_INDEX_W     = 3;

   // opcodes of an input beat
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_OPEN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_EXTEND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_GAP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISMATCH   = 3'd4;

   // register reset values, in half units
   localparam logic [CFG_W-1:0] GAP_OPEN_RESET   = 8'd4;
   localparam logic [CFG_W-1:0] GAP_EXTEND_RESET = 8'd1;
   localparam logic [CFG_W-1:0] START_GAP_RESET  = 8'd4;
   localparam logic [CFG_W-1:0] MATCH_RESET      = 8'd0;
   localparam logic [CFG_W-1:0] MISMATCH_RESET   = 8'd2;

   typedef struct packed {
      logic                opcode;
      logic [SYMBOL_W-1:0] symbol;
      logic                final_symbol;
   } req_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [COST_W-1:0]   best_cost;
      logic [COST_W-1:0]   deletion_cost;
      logic                row_end;
   } rsp_type;

   // one entry of the row memory
   typedef struct packed {
      logic [COST_W-1:0] best;
      logic [COST_W-1:0] deletion;
   } row_entry_type;

   // costs seen by one column cell
   typedef struct packed {
      logic [CFG_W-1:0] gap_open;
      logic [CFG_W-1:0] gap_extend;
      logic [CFG_W-1:0] subst;
   } cell_cost_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW0,
      ST_COL,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

   // add that clips at the top of the cost range
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
   endfunction

   function automatic logic [COST_W-1:0] min_cost(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/affine_gap_alignment_last_row_core.sv
`default_nettype none

// channel  dir  signals                              beat
// req      in   req_valid req_ready req_data         one symbol: load or query
// rsp      out  rsp_valid rsp_ready rsp_data         one column of the final row
// csr      in   csr_valid csr_ready csr_index/data   one cost register write
//
// a load beat is written straight into the reference memory. a query beat holds the input
// while the row pass runs over the N reference columns: the accept cycle fetches column 0,
// ST_ROW0 writes it, then ST_COL takes one column per cycle through the simple dual-port row
// memory. after the final query beat ST_OUT_RD fetches column 0 and N+1 results follow, one per cycle while
// rsp_ready is high. reset is synchronous; the memories hold garbage until written.
// a stalled rsp beat holds in the output register and blocks the input until the
// last column has been taken into it.

module affine_gap_alignment_last_row_core import agal_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_data
);

   localparam int ROW_DEPTH = MAX_LEN + 1;
   localparam int COL_W     = $clog2(ROW_DEPTH);
   localparam int REF_AW    = $clog2(MAX_LEN);

   // cost registers
   logic [CFG_W-1:0] gap_open_ff;
   logic [CFG_W-1:0] gap_extend_ff;
   logic [CFG_W-1:0] start_gap_ff;
   logic [CFG_W-1:0] match_ff;
   logic [CFG_W-1:0] mismatch_ff;

   // control state
   state_type         state_ff;
   state_type         state_in;
   logic [COL_W-1:0]  len_ff;
   logic              done_ff;
   logic              active_ff;
   logic [COST_W-1:0] left_ff;
   logic [COL_W-1:0]  col_ff;
   logic              rsp_valid_ff;

   // per-symbol working registers
   logic [SYMBOL_W-1:0] sym_ff;
   logic                fin_ff;
   logic                init_ff;
   logic [COST_W-1:0]   s_ff;
   logic [COST_W-1:0]   c_ff;
   logic [COST_W-1:0]   e_ff;
   logic [COST_W-1:0]   ib_ff;
   rsp_type             rsp_data_ff;

   // memories
   row_entry_type       row_mem [ROW_DEPTH];
   row_entry_type       row_rd_ff;
   logic [SYMBOL_W-1:0] ref_mem [MAX_LEN];
   logic [SYMBOL_W-1:0] ref_rd_ff;

   // memory controls
   logic                row_re;
   logic [COL_W-1:0]    row_raddr;
   logic                row_we;
   logic [COL_W-1:0]    row_waddr;
   row_entry_type       row_wdata;
   logic                ref_re;
   logic [REF_AW-1:0]   ref_raddr;
   logic                rsp_load;

   // datapath
   logic                req_accept;
   logic                query_go;
   logic                load_go;
   logic                slot_free;
   logic [COL_W-1:0]    eff_len;
   logic [COL_W-1:0]    col_next;
   logic [COST_W-1:0]   g16;
   logic [COST_W-1:0]   h16;
   logic [COST_W-1:0]   t0;
   logic [COST_W-1:0]   up_best;
   logic [COST_W-1:0]   up_del;
   cell_cost_type       cell_cost;
   logic [COST_W-1:0]   cell_best;
   logic [COST_W-1:0]   cell_del;
   logic [COST_W-1:0]   cell_ins;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign query_go   = req_accept && (req_data.opcode == OP_QUERY) && done_ff;
   assign load_go    = req_accept && (req_data.opcode == OP_LOAD);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign eff_len    = done_ff ? '0 : len_ff;
   assign col_next   = COL_W'(col_ff + 1'b1);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign g16 = COST_W'(gap_open_ff);
   assign h16 = COST_W'(gap_extend_ff);

   // column 0 of the new row: the left boundary moves down by one extend
   assign t0 = sat_add(init_ff ? COST_W'(start_gap_ff) : left_ff, h16);

   // row above: the top row on the first query symbol, else the memory
   assign up_best = init_ff ? ib_ff : row_rd_ff.best;
   assign up_del  = init_ff ? sat_add(ib_ff, g16) : row_rd_ff.deletion;

   assign cell_cost.gap_open   = gap_open_ff;
   assign cell_cost.gap_extend = gap_extend_ff;
   assign cell_cost.subst      = (sym_ff == ref_rd_ff) ? match_ff : mismatch_ff;

   agal_cell u_cell (
      .cost      (cell_cost),
      .prev_best (s_ff),
      .up_best   (up_best),
      .up_del    (up_del),
      .left_best (c_ff),
      .left_ins  (e_ff),
      .new_best  (cell_best),
      .new_del   (cell_del),
      .new_ins   (cell_ins)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) state_in = ST_ROW0;
         end
         ST_ROW0: begin
            if (len_ff == '0) state_in = fin_ff ? ST_OUT_RD : ST_IDLE;
            else              state_in = ST_COL;
         end
         ST_COL: begin
            if (col_ff == len_ff) state_in = fin_ff ? ST_OUT_RD : ST_IDLE;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (slot_free && (col_ff == len_ff)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory and output controls
   always_comb begin
      row_re    = 1'b0;
      row_raddr = '0;
      row_we    = 1'b0;
      row_waddr = '0;
      row_wdata = '0;
      ref_re    = 1'b0;
      ref_raddr = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) row_re = 1'b1;
         end
         ST_ROW0: begin
            row_we             = 1'b1;
            row_wdata.best     = t0;
            row_wdata.deletion = t0;
            if (len_ff != '0) begin
               row_re    = 1'b1;
               row_raddr = COL_W'(1);
               ref_re    = 1'b1;
            end
         end
         ST_COL: begin
            row_we             = 1'b1;
            row_waddr          = col_ff;
            row_wdata.best     = cell_best;
            row_wdata.deletion = cell_del;
            if (col_ff != len_ff) begin
               row_re    = 1'b1;
               row_raddr = col_next;
               ref_re    = 1'b1;
               ref_raddr = REF_AW'(col_ff);
            end
         end
         ST_OUT_RD: begin
            row_re = 1'b1;
         end
         ST_OUT_WAIT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (col_ff != len_ff) begin
                  row_re    = 1'b1;
                  row_raddr = col_next;
               end
            end
         end
         default: begin
            row_re = 1'b0;
         end
      endcase
   end

   // row memory
   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_waddr] <= row_wdata;
      if (row_re) row_rd_ff <= row_mem[row_raddr];
   end

   // reference memory
   always_ff @(posedge clock) begin
      if (load_go && (eff_len < COL_W'(MAX_LEN))) begin
         ref_mem[REF_AW'(eff_len)] <= req_data.symbol;
      end
      if (ref_re) ref_rd_ff <= ref_mem[ref_raddr];
   end

   // cost registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff   <= GAP_OPEN_RESET;
         gap_extend_ff <= GAP_EXTEND_RESET;
         start_gap_ff  <= START_GAP_RESET;
         match_ff      <= MATCH_RESET;
         mismatch_ff   <= MISMATCH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAP_OPEN:   gap_open_ff   <= csr_data;
            CSR_GAP_EXTEND: gap_extend_ff <= csr_data;
            CSR_START_GAP:  start_gap_ff  <= csr_data;
            CSR_MATCH:      match_ff      <= csr_data;
            CSR_MISMATCH:   mismatch_ff   <= csr_data;
            default:        gap_open_ff   <= gap_open_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         done_ff      <= 1'b0;
         active_ff    <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // reference load, a load after a complete reference starts over
         if (load_go) begin
            if (eff_len < COL_W'(MAX_LEN)) len_ff <= COL_W'(eff_len + 1'b1);
            else                           len_ff <= eff_len;
            done_ff <= req_data.final_symbol;
            if (done_ff) active_ff <= 1'b0;
         end
         if (query_go) active_ff <= !req_data.final_symbol;
         if (state_ff == ST_ROW0) left_ff <= t0;
         if (rsp_load)          rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   // working registers of the row pass and the output register
   always_ff @(posedge clock) begin
      if (query_go) begin
         sym_ff  <= req_data.symbol;
         fin_ff  <= req_data.final_symbol;
         init_ff <= !active_ff;
      end
      case (state_ff)
         ST_ROW0: begin
            s_ff   <= init_ff ? '0 : row_rd_ff.best;
            c_ff   <= t0;
            e_ff   <= sat_add(t0, g16);
            ib_ff  <= sat_add(g16, h16);
            col_ff <= COL_W'(1);
         end
         ST_COL: begin
            s_ff   <= up_best;
            c_ff   <= cell_best;
            e_ff   <= cell_ins;
            ib_ff  <= sat_add(ib_ff, h16);
            col_ff <= col_next;
         end
         ST_OUT_RD: begin
            col_ff <= '0;
         end
         ST_OUT_WAIT: begin
            if (rsp_load) col_ff <= col_next;
         end
         default: begin
            col_ff <= col_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_data_ff.column        <= COLUMN_W'(col_ff);
         rsp_data_ff.best_cost     <= row_rd_ff.best;
         rsp_data_ff.deletion_cost <= row_rd_ff.deletion;
         rsp_data_ff.row_end       <= (col_ff == len_ff);
      end
   end

endmodule

`default_nettype wire

>>> rtl/agal_cell.sv
`default_nettype none

module agal_cell import agal_pkg::*; (
   input  wire cell_cost_type     cost,
   input  wire logic [COST_W-1:0] prev_best,
   input  wire logic [COST_W-1:0] up_best,
   input  wire logic [COST_W-1:0] up_del,
   input  wire logic [COST_W-1:0] left_best,
   input  wire logic [COST_W-1:0] left_ins,
   output logic [COST_W-1:0]      new_best,
   output logic [COST_W-1:0]      new_del,
   output logic [COST_W-1:0]      new_ins
);

   logic [COST_W-1:0] g;
   logic [COST_W-1:0] h;
   logic [COST_W-1:0] diag;

   assign g = COST_W'(cost.gap_open);
   assign h = COST_W'(cost.gap_extend);

   // deletion from the row above, insertion along the row, diagonal step
   always_comb begin
      new_del  = sat_add(min_cost(up_del, sat_add(up_best, g)), h);
      new_ins  = sat_add(min_cost(left_ins, sat_add(left_best, g)), h);
      diag     = sat_add(prev_best, COST_W'(cost.subst));
      new_best = min_cost(min_cost(new_del, new_ins), diag);
   end

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import agal_pkg::*;

   localparam int REF_DEPTH     = MAX_LEN_DEFAULT;
   localparam int CLOCK_HALF    = 5;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_BEATS   = 12;
   localparam int SAT_ROWS      = 264;
   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_data;

   // predicted block state
   logic [SYMBOL_W-1:0] ref_symbols [REF_DEPTH];
   int                  ref_len;
   bit                  ref_complete;
   bit                  query_open;
   logic [COST_W-1:0]   cc_row [REF_DEPTH+1];
   logic [COST_W-1:0]   dd_row [REF_DEPTH+1];
   logic [COST_W-1:0]   left_cost;
   logic [CFG_W-1:0]    open_cost;
   logic [CFG_W-1:0]    extend_cost;
   logic [CFG_W-1:0]    start_cost;
   logic [CFG_W-1:0]    equal_cost;
   logic [CFG_W-1:0]    differ_cost;

   rsp_type expected_columns [$];
   int      mismatches;
   int      useful_beats;
   int      hold_off_requests;
   bit      sender_gaps;
   bit      receiver_gaps;

   affine_gap_alignment_last_row_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // cost sum clipped at the top of the 16-bit range
   function automatic logic [COST_W-1:0] clip_sum(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      logic [COST_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[COST_W] ? {COST_W{1'b1}} : total[COST_W-1:0];
   endfunction

   function automatic logic [COST_W-1:0] lower(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

   function automatic logic [SYMBOL_W-1:0] pick_symbol(input bit narrow);
      return narrow ? SYMBOL_W'($urandom_range(0, 3)) : SYMBOL_W'($urandom_range(0, 127));
   endfunction

   // advance the predicted state by one accepted beat, queue any final row
   task automatic predict_beat(input req_type beat);
      int                j;
      logic [COST_W-1:0] run;
      logic [COST_W-1:0] diag_prev;
      logic [COST_W-1:0] ins_run;
      logic [COST_W-1:0] del_cost;
      logic [COST_W-1:0] subst;
      logic [COST_W-1:0] diag;
      rsp_type           column_result;
      if (beat.opcode == OP_LOAD) begin
         // a load after a finished reference begins a new one
         if (ref_complete) begin
            ref_len      = 0;
            ref_complete = 0;
            query_open   = 0;
         end
         if (ref_len < REF_DEPTH) begin
            ref_symbols[ref_len] = beat.symbol;
            ref_len++;
            useful_beats++;
         end
         if (beat.final_symbol) ref_complete = 1;
      end else if (ref_complete) begin
         useful_beats++;
         // top row on the first symbol of a query
         if (!query_open) begin
            run       = COST_W'(open_cost);
            cc_row[0] = '0;
            dd_row[0] = '0;
            for (j = 1; j <= ref_len; j++) begin
               run       = clip_sum(run, COST_W'(extend_cost));
               cc_row[j] = run;
               dd_row[j] = clip_sum(run, COST_W'(open_cost));
            end
            left_cost  = COST_W'(start_cost);
            query_open = 1;
         end
         // one row of the recurrence
         diag_prev = cc_row[0];
         run       = clip_sum(left_cost, COST_W'(extend_cost));
         left_cost = run;
         cc_row[0] = run;
         dd_row[0] = run;
         ins_run   = clip_sum(run, COST_W'(open_cost));
         for (j = 1; j <= ref_len; j++) begin
            ins_run   = clip_sum(lower(ins_run, clip_sum(run, COST_W'(open_cost))),
                                 COST_W'(extend_cost));
            del_cost  = clip_sum(lower(dd_row[j], clip_sum(cc_row[j], COST_W'(open_cost))),
                                 COST_W'(extend_cost));
            dd_row[j] = del_cost;
            subst     = (beat.symbol == ref_symbols[j-1]) ? COST_W'(equal_cost)
                                                          : COST_W'(differ_cost);
            diag      = clip_sum(diag_prev, subst);
            run       = lower(lower(del_cost, ins_run), diag);
            diag_prev = cc_row[j];
            cc_row[j] = run;
         end
         if (beat.final_symbol) begin
            query_open = 0;
            for (j = 0; j <= ref_len; j++) begin
               column_result.column        = COLUMN_W'(j);
               column_result.best_cost     = cc_row[j];
               column_result.deletion_cost = dd_row[j];
               column_result.row_end       = (j == ref_len);
               expected_columns.push_back(column_result);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // compare every result beat with the oldest expected column
   always @(posedge clock) begin : column_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_columns.size() == 0) begin
            report_mismatch("unexpected rsp beat, column", int'(rsp_data.column), -1);
         end else begin
            want = expected_columns.pop_front();
            if (rsp_data.column !== want.column)
               report_mismatch("column", int'(rsp_data.column), int'(want.column));
            if (rsp_data.best_cost !== want.best_cost)
               report_mismatch("best_cost", int'(rsp_data.best_cost), int'(want.best_cost));
            if (rsp_data.deletion_cost !== want.deletion_cost)
               report_mismatch("deletion_cost", int'(rsp_data.deletion_cost),
                               int'(want.deletion_cost));
            if (rsp_data.row_end !== want.row_end)
               report_mismatch("row_end", int'(rsp_data.row_end), int'(want.row_end));
         end
      end
   end

   // result receiver: long hold-offs on request take priority, else random stall bursts
   initial begin : receiver
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_ready  = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_requests != hold_seen) begin
            hold_seen = hold_off_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one beat, wait for the handshake, predict, maybe pause
   task automatic send_beat(input logic op, input logic [SYMBOL_W-1:0] sym, input logic fin);
      req_type beat;
      int      gap;
      beat.opcode       = op;
      beat.symbol       = sym;
      beat.final_symbol = fin;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      predict_beat(beat);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering, wait out all expected columns and any query still running
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_GAP_OPEN:   open_cost   = value;
         CSR_GAP_EXTEND: extend_cost = value;
         CSR_START_GAP:  start_cost  = value;
         CSR_MATCH:      equal_cost  = value;
         CSR_MISMATCH:   differ_cost = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_costs(input logic [CFG_W-1:0] open_v, input logic [CFG_W-1:0] ext_v,
                            input logic [CFG_W-1:0] start_v, input logic [CFG_W-1:0] eq_v,
                            input logic [CFG_W-1:0] diff_v);
      write_register(CSR_GAP_OPEN, open_v);
      write_register(CSR_GAP_EXTEND, ext_v);
      write_register(CSR_START_GAP, start_v);
      write_register(CSR_MATCH, eq_v);
      write_register(CSR_MISMATCH, diff_v);
   endtask

   task automatic load_reference(input int len, input bit narrow);
      int i;
      for (i = 0; i < len; i++) send_beat(OP_LOAD, pick_symbol(narrow), i == len - 1);
   endtask

   task automatic run_query(input int len, input bit narrow);
      int i;
      for (i = 0; i < len; i++) send_beat(OP_QUERY, pick_symbol(narrow), i == len - 1);
   endtask

   // symbol extremes, ignored queries, repeated and interrupted queries
   task automatic test_directed_cases();
      // no reference yet: queries are dropped
      send_beat(OP_QUERY, 7'd5, 1'b0);
      send_beat(OP_QUERY, 7'd9, 1'b1);
      send_beat(OP_LOAD, 7'd0, 1'b0);
      send_beat(OP_LOAD, 7'd127, 1'b0);
      send_beat(OP_LOAD, 7'd3, 1'b1);
      send_beat(OP_QUERY, 7'd127, 1'b0);
      send_beat(OP_QUERY, 7'd0, 1'b0);
      send_beat(OP_QUERY, 7'd3, 1'b1);
      // next query reuses the same reference
      send_beat(OP_QUERY, 7'd64, 1'b1);
      // load mid-query drops the query and starts a new reference
      send_beat(OP_QUERY, 7'd1, 1'b0);
      send_beat(OP_LOAD, 7'd1, 1'b1);
      send_beat(OP_QUERY, 7'd1, 1'b1);
      // query while the reference is still being loaded
      send_beat(OP_LOAD, 7'd5, 1'b0);
      send_beat(OP_QUERY, 7'd5, 1'b1);
      send_beat(OP_LOAD, 7'd6, 1'b1);
      send_beat(OP_QUERY, 7'd6, 1'b0);
      send_beat(OP_QUERY, 7'd5, 1'b1);
      drain_results();
   endtask

   // every register at zero and at full scale, plus a write to an unused index
   task automatic test_register_extremes();
      set_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      load_reference(3, 1'b1);
      run_query(3, 1'b1);
      drain_results();
      set_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      load_reference(2, 1'b0);
      run_query(2, 1'b0);
      drain_results();
      set_costs(8'd255, 8'd1, 8'd0, 8'd0, 8'd255);
      write_register(CSR_SPARE, 8'hA5);
      load_reference(4, 1'b1);
      run_query(4, 1'b1);
      drain_results();
      set_costs(GAP_OPEN_RESET, GAP_EXTEND_RESET, START_GAP_RESET, MATCH_RESET,
                MISMATCH_RESET);
   endtask

   // loads past the store depth are dropped, a final mark on one still ends the reference
   task automatic test_reference_overflow();
      int i;
      for (i = 0; i < REF_DEPTH + 2; i++)
         send_beat(OP_LOAD, pick_symbol(1'b0), i == REF_DEPTH + 1);
      run_query(3, 1'b1);
      drain_results();
   endtask

   // long query at full-scale costs on the full-length reference drives every sum
   // into the clip
   task automatic test_saturation();
      sender_gaps = 0;
      set_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      run_query(SAT_ROWS, 1'b1);
      drain_results();
      sender_gaps = 1;
   endtask

   // receiver holds off while query beats keep coming, then a full pause
   task automatic test_backpressure();
      int i;
      set_costs(GAP_OPEN_RESET, GAP_EXTEND_RESET, START_GAP_RESET, MATCH_RESET,
                MISMATCH_RESET);
      hold_off_requests++;
      for (i = 0; i < 4; i++) run_query(2, 1'b1);
      drain_results();
   endtask

   // one random sequence: mostly well-formed reference and queries, some noise
   task automatic send_random_sequence();
      int kind;
      int i;
      int len;
      bit narrow;
      kind   = $urandom_range(0, 9);
      narrow = 1'($urandom_range(0, 1));
      if (kind == 0) begin
         send_beat(1'($urandom_range(0, 1)), pick_symbol(1'b0), 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
         // reference left open, query beats on it are dropped
         len = $urandom_range(1, 4);
         for (i = 0; i < len; i++) send_beat(OP_LOAD, pick_symbol(narrow), 1'b0);
         run_query($urandom_range(1, 3), narrow);
      end else begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, REF_DEPTH + 2)
                                           : $urandom_range(1, 8);
         load_reference(len, narrow);
         len = $urandom_range(1, 3);
         for (i = 0; i < len; i++) run_query($urandom_range(1, 6), narrow);
         // unfinished query, dropped by the next load
         if ($urandom_range(0, 4) == 0)
            send_beat(OP_QUERY, pick_symbol(narrow), 1'b0);
      end
   endtask

   // random traffic over several cost settings, last phase without idling
   task automatic test_random_traffic();
      int phase;
      int target;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_costs(GAP_OPEN_RESET, GAP_EXTEND_RESET, START_GAP_RESET, MATCH_RESET,
                         MISMATCH_RESET);
            1: set_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            2: set_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            default: set_costs(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                               CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                               CFG_W'($urandom_range(0, 255)));
         endcase
         target = useful_beats + PHASE_BEATS;
         while (useful_beats < target) begin
            sender_gaps   = (phase != 5) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (phase != 5) && ($urandom_range(0, 3) != 0);
            send_random_sequence();
         end
         drain_results();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      ref_len           = 0;
      ref_complete      = 0;
      query_open        = 0;
      left_cost         = '0;
      open_cost         = GAP_OPEN_RESET;
      extend_cost       = GAP_EXTEND_RESET;
      start_cost        = START_GAP_RESET;
      equal_cost        = MATCH_RESET;
      differ_cost       = MISMATCH_RESET;
      mismatches        = 0;
      useful_beats      = 0;
      hold_off_requests = 0;
      sender_gaps       = 1;
      receiver_gaps     = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_reference_overflow();
      test_saturation();
      test_backpressure();
      test_random_traffic();
      drain_results();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
